// File: src/bart_pkg.sv
// ----------------------------------------------------------------------------
// bart_pkg
// Shared widths, codes and structures of the bump allocator residency table.
// ----------------------------------------------------------------------------
package bart_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW         = $clog2(TableEntries);
  // The alignment must be a power of two: rounding is done by masking.
  localparam int AlignBytes   = 64;
  localparam int AlignW       = $clog2(AlignBytes);

  localparam int OpW     = 3;
  localparam int KeyW    = 64;
  localparam int SizeW   = 41;
  localparam int AddrW   = 48;
  localparam int StatusW = 3;
  localparam int ResW    = 2;
  localparam int SumW    = SizeW + 1;
  localparam int AluW    = AddrW;

  localparam logic [SizeW-1:0] CapReset = 41'd17179869184;

  localparam logic [OpW-1:0] OpAlloc   = 3'd0;
  localparam logic [OpW-1:0] OpFree    = 3'd1;
  localparam logic [OpW-1:0] OpEvict   = 3'd2;
  localparam logic [OpW-1:0] OpPromote = 3'd3;
  localparam logic [OpW-1:0] OpPin     = 3'd4;
  localparam logic [OpW-1:0] OpUnpin   = 3'd5;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoSpace  = 3'd1;
  localparam logic [StatusW-1:0] StNotFound = 3'd2;
  localparam logic [StatusW-1:0] StPinned   = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;

  localparam logic [ResW-1:0] ResWarm   = 2'd0;
  localparam logic [ResW-1:0] ResHot    = 2'd1;
  localparam logic [ResW-1:0] ResCold   = 2'd2;
  localparam logic [ResW-1:0] ResPinned = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [KeyW-1:0]  tensor_key;
    logic [SizeW-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   granted_address;
    logic [ResW-1:0]    entry_state;
    logic [SizeW-1:0]   free_bytes;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] size;
    logic [ResW-1:0]  residency;
    logic             pinned;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0] rd_idx;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            wr_valid;
  } tbl_ctrl_t;

  typedef struct packed {
    logic sub;
  } alu_ctrl_t;

  typedef struct packed {
    logic            carry;
    logic [AluW-1:0] value;
  } alu_res_t;

endpackage

// File: src/bart_alu.sv
// ----------------------------------------------------------------------------
// bart_alu
// Shared adder and subtractor; the carry out doubles as the borrow flag.
// ----------------------------------------------------------------------------
module bart_alu (
  input  bart_pkg::alu_ctrl_t          ctrl_i,
  input  logic [bart_pkg::AluW-1:0]    a_i,
  input  logic [bart_pkg::AluW-1:0]    b_i,
  output bart_pkg::alu_res_t           res_o
);

  logic [bart_pkg::AluW:0] sum;

  always_comb begin
    if (ctrl_i.sub) begin
      sum = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end
    res_o.carry = sum[bart_pkg::AluW];
    res_o.value = sum[bart_pkg::AluW-1:0];
  end

endmodule

// File: src/bart_table.sv
// ----------------------------------------------------------------------------
// bart_table
// Entry memory with one write and one registered read port, plus valid bits.
// ----------------------------------------------------------------------------
module bart_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bart_pkg::tbl_ctrl_t   ctrl_i,
  input  bart_pkg::entry_t      wr_entry_i,
  output bart_pkg::entry_t      rd_entry_o,
  output logic                  rd_valid_o
);

  bart_pkg::entry_t                  mem_q [bart_pkg::TableEntries];
  bart_pkg::entry_t                  rd_entry_q;
  logic [bart_pkg::TableEntries-1:0] vld_q;
  logic                              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_idx] <= wr_entry_i;
    end
    rd_entry_q <= mem_q[ctrl_i.rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[ctrl_i.wr_idx] <= ctrl_i.wr_valid;
      end
      rd_valid_q <= vld_q[ctrl_i.rd_idx];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// File: src/bump_allocator_residency_table_core.sv
// ----------------------------------------------------------------------------
// bump_allocator_residency_table_core
// Bump allocator with a residency table, run by a small sequencer over one
// shared adder and an entry table with one read and one write port.
// ----------------------------------------------------------------------------
// Usage: a request transaction (operation, key, size) enters on in_valid_i
// when in_stall_o is low; in_stall_o stays high while a request is being
// worked on. Each request gives exactly one response transaction on
// out_valid_o, held stable while out_stall_i is high. A new request may be
// taken while the previous response still waits in the output register.
// Sequence: the table is scanned one entry per cycle through its only read
// port, and the arithmetic steps that an operation needs (space check,
// rounding, pointer advance, free bytes) then follow one after another on
// the shared adder. The next request is taken only once the response to
// the previous one is registered, so requests are worked on one at a time.
// The capacity register is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, as the block itself
// does not enforce this. Reset clears the bytes in use, the bump pointer
// and every valid bit at once, and loads the capacity with its default.
// If the receiver stalls, the finished response waits until the output
// register is free.
// ----------------------------------------------------------------------------
module bump_allocator_residency_table_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bart_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bart_pkg::rsp_t                 out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [bart_pkg::SizeW-1:0]     cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_DRAIN    = 4'd2;
  localparam logic [3:0] ST_DISPATCH = 4'd3;
  localparam logic [3:0] ST_SUM      = 4'd4;
  localparam logic [3:0] ST_CHECK    = 4'd5;
  localparam logic [3:0] ST_ROUND    = 4'd6;
  localparam logic [3:0] ST_BUMP     = 4'd7;
  localparam logic [3:0] ST_COMMIT   = 4'd8;
  localparam logic [3:0] ST_FREEB    = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  localparam logic [bart_pkg::IdxW-1:0] LastIdx = bart_pkg::IdxW'(bart_pkg::TableEntries - 1);
  localparam logic [bart_pkg::AluW-1:0] AlignMinusOne =
    bart_pkg::AluW'(bart_pkg::AlignBytes - 1);

  logic [3:0]                    state_q, state_d;
  logic [bart_pkg::SizeW-1:0]    cap_q;
  logic [bart_pkg::SizeW-1:0]    used_q;
  logic [bart_pkg::AddrW-1:0]    bump_q;
  logic                          hit_q;
  logic                          free_found_q;
  logic                          cmp_vld_q;
  logic                          out_valid_q;

  bart_pkg::req_t                req_q;
  bart_pkg::entry_t              ent_q;
  logic [bart_pkg::IdxW-1:0]     scan_idx_q;
  logic [bart_pkg::IdxW-1:0]     cmp_idx_q;
  logic [bart_pkg::IdxW-1:0]     hit_idx_q;
  logic [bart_pkg::IdxW-1:0]     free_idx_q;
  logic [bart_pkg::SumW-1:0]     t_q;
  logic [bart_pkg::SumW-1:0]     r_q;
  bart_pkg::rsp_t                res_q;
  bart_pkg::rsp_t                out_rsp_q;

  bart_pkg::tbl_ctrl_t           tbl_ctrl;
  bart_pkg::entry_t              rd_entry;
  logic                          rd_valid;
  bart_pkg::alu_ctrl_t           alu_ctrl;
  logic [bart_pkg::AluW-1:0]     alu_a;
  logic [bart_pkg::AluW-1:0]     alu_b;
  bart_pkg::alu_res_t            alu_res;

  logic                          accept;
  logic                          out_free;
  logic                          key_match;
  logic                          is_alloc;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign key_match = rd_valid && (rd_entry.key == req_q.tensor_key);
  assign is_alloc  = (req_q.operation == bart_pkg::OpAlloc);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  bart_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tbl_ctrl),
    .wr_entry_i (ent_q),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  bart_alu u_alu (
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res)
  );

  always_comb begin
    tbl_ctrl.rd_idx   = scan_idx_q;
    tbl_ctrl.wr_en    = (state_q == ST_COMMIT);
    tbl_ctrl.wr_idx   = (is_alloc && !hit_q) ? free_idx_q : hit_idx_q;
    tbl_ctrl.wr_valid = (req_q.operation != bart_pkg::OpFree);
  end

  // Operand selection for the shared adder, one arithmetic step per state.
  always_comb begin
    alu_ctrl.sub = 1'b0;
    alu_a        = '0;
    alu_b        = '0;
    unique case (state_q)
      ST_SUM: begin
        alu_a = bart_pkg::AluW'(used_q);
        if (is_alloc) begin
          alu_b = bart_pkg::AluW'(req_q.request_size);
        end else begin
          alu_ctrl.sub = 1'b1;
          alu_b        = bart_pkg::AluW'(ent_q.size);
        end
      end
      ST_CHECK: begin
        alu_ctrl.sub = 1'b1;
        alu_a        = bart_pkg::AluW'(cap_q);
        alu_b        = bart_pkg::AluW'(t_q);
      end
      ST_ROUND: begin
        alu_a = bart_pkg::AluW'(req_q.request_size);
        alu_b = AlignMinusOne;
      end
      ST_BUMP: begin
        alu_a = bump_q;
        alu_b = bart_pkg::AluW'(r_q);
      end
      ST_FREEB: begin
        alu_ctrl.sub = 1'b1;
        alu_a        = bart_pkg::AluW'(cap_q);
        alu_b        = bart_pkg::AluW'(used_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (req_q.operation) inside
          bart_pkg::OpAlloc: state_d = ST_SUM;
          bart_pkg::OpFree:  state_d = hit_q ? ST_SUM : ST_FREEB;
          bart_pkg::OpEvict: state_d = (hit_q && !ent_q.pinned) ? ST_COMMIT : ST_FREEB;
          bart_pkg::OpPromote, bart_pkg::OpPin, bart_pkg::OpUnpin: begin
            state_d = hit_q ? ST_COMMIT : ST_FREEB;
          end
          default: state_d = ST_FREEB;
        endcase
      end
      ST_SUM: state_d = is_alloc ? ST_CHECK : ST_COMMIT;
      ST_CHECK: begin
        if (alu_res.carry || (!hit_q && !free_found_q)) begin
          state_d = ST_FREEB;
        end else begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND:  state_d = ST_BUMP;
      ST_BUMP:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FREEB;
      ST_FREEB:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and architectural counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= bart_pkg::CapReset;
      used_q       <= '0;
      bump_q       <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (cmp_vld_q) begin
        if (key_match) begin
          hit_q <= 1'b1;
        end
        if (!rd_valid) begin
          free_found_q <= 1'b1;
        end
      end
      if (state_q == ST_SUM && !is_alloc) begin
        // Freeing more than is counted saturates at zero.
        used_q <= alu_res.carry ? '0 : alu_res.value[bart_pkg::SizeW-1:0];
      end
      if (state_q == ST_BUMP) begin
        bump_q <= alu_res.value;
        used_q <= t_q[bart_pkg::SizeW-1:0];
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, entry and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      scan_idx_q <= scan_idx_q + 1'b1;
    end
    cmp_idx_q <= scan_idx_q;
    if (accept) begin
      req_q                 <= in_req_i;
      scan_idx_q            <= '0;
      res_q.status          <= bart_pkg::StOk;
      res_q.granted_address <= '0;
      res_q.entry_state     <= bart_pkg::ResWarm;
    end
    if (cmp_vld_q) begin
      // Keys are unique among valid entries, so the first match is the only one.
      if (key_match && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
        ent_q     <= rd_entry;
      end
      if (!rd_valid && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    unique case (state_q)
      ST_DISPATCH: begin
        if (!hit_q && !is_alloc && req_q.operation <= bart_pkg::OpUnpin) begin
          res_q.status <= bart_pkg::StNotFound;
        end else begin
          unique case (req_q.operation)
            bart_pkg::OpEvict: begin
              if (ent_q.pinned) begin
                res_q.status      <= bart_pkg::StPinned;
                res_q.entry_state <= ent_q.residency;
              end else begin
                ent_q.residency   <= bart_pkg::ResCold;
                res_q.entry_state <= bart_pkg::ResCold;
              end
            end
            bart_pkg::OpPromote: begin
              ent_q.residency   <= bart_pkg::ResHot;
              res_q.entry_state <= bart_pkg::ResHot;
            end
            bart_pkg::OpPin: begin
              ent_q.pinned      <= 1'b1;
              ent_q.residency   <= bart_pkg::ResPinned;
              res_q.entry_state <= bart_pkg::ResPinned;
            end
            bart_pkg::OpUnpin: begin
              ent_q.pinned      <= 1'b0;
              ent_q.residency   <= bart_pkg::ResHot;
              res_q.entry_state <= bart_pkg::ResHot;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM: begin
        if (is_alloc) begin
          t_q <= alu_res.value[bart_pkg::SumW-1:0];
        end
      end
      ST_CHECK: begin
        if (alu_res.carry) begin
          res_q.status <= bart_pkg::StNoSpace;
        end else if (!hit_q && !free_found_q) begin
          res_q.status <= bart_pkg::StFull;
        end
      end
      ST_ROUND: begin
        r_q <= {alu_res.value[bart_pkg::SumW-1:bart_pkg::AlignW], {bart_pkg::AlignW{1'b0}}};
      end
      ST_BUMP: begin
        ent_q.key             <= req_q.tensor_key;
        ent_q.address         <= bump_q;
        ent_q.size            <= req_q.request_size;
        ent_q.residency       <= bart_pkg::ResWarm;
        ent_q.pinned          <= 1'b0;
        res_q.granted_address <= bump_q;
      end
      ST_FREEB: begin
        res_q.free_bytes <= alu_res.carry ? '0 : alu_res.value[bart_pkg::SizeW-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_rsp_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

  // The pointer only ever advances by aligned amounts from zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q[bart_pkg::AlignW-1:0] == '0)
    else $error("bump pointer lost its alignment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the completion step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != bart_pkg::StOk) |->
      (out_rsp_o.granted_address == '0))
    else $error("failed request carries an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) && is_alloc |-> (hit_q || free_found_q))
    else $error("allocation committed without a target entry");

endmodule

// File: tb/bart_allocation_checker.sv
// ----------------------------------------------------------------------------
// bart_allocation_checker
// Watches the request, response and capacity ports of the allocator, keeps
// its own copy of the usage count, bump pointer and entry table, works out
// the response owed for every accepted request and compares each response
// field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module bart_allocation_checker import bart_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  req_t             in_req_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  rsp_t             out_rsp_i,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  output int               owed_o,
  output int               fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SizeW-1:0] capacity_q;
  logic [SizeW-1:0] in_use_q;
  logic [AddrW-1:0] bump_q;
  logic             live_q [TableEntries];
  entry_t           slot_q [TableEntries];
  rsp_t             owed_q [$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int find_slot(input logic [KeyW-1:0] key);
    int i;
    for (i = 0; i < TableEntries; i++) begin
      if (live_q[i] && slot_q[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic int first_free();
    int i;
    for (i = 0; i < TableEntries; i++) begin
      if (!live_q[i]) return i;
    end
    return -1;
  endfunction

  // Applies one request to the allocator state and returns its response.
  function automatic rsp_t apply_request(input req_t req);
    rsp_t            rsp;
    int              idx;
    logic [SumW-1:0] total;
    logic [63:0]     next_ptr;
    rsp = '0;
    idx = find_slot(req.tensor_key);
    if (req.operation == OpAlloc) begin
      total = SumW'(in_use_q) + SumW'(req.request_size);
      if (total > SumW'(capacity_q)) begin
        rsp.status = StNoSpace;
      end else begin
        if (idx < 0) idx = first_free();
        if (idx < 0) begin
          rsp.status = StFull;
        end else begin
          // The pointer moves on to the next alignment boundary and wraps.
          next_ptr = 64'(bump_q) + 64'(req.request_size) + 64'(AlignBytes - 1);
          next_ptr = next_ptr & ~64'(AlignBytes - 1);
          rsp.granted_address       = bump_q;
          rsp.entry_state           = ResWarm;
          bump_q                    = next_ptr[AddrW-1:0];
          live_q[idx]               = 1'b1;
          slot_q[idx].key           = req.tensor_key;
          slot_q[idx].address       = rsp.granted_address;
          slot_q[idx].size          = req.request_size;
          slot_q[idx].residency     = ResWarm;
          slot_q[idx].pinned        = 1'b0;
          // An overwritten entry leaves its old size counted.
          in_use_q                  = total[SizeW-1:0];
        end
      end
    end else if (req.operation <= OpUnpin) begin
      if (idx < 0) begin
        rsp.status = StNotFound;
      end else begin
        case (req.operation)
          OpFree: begin
            in_use_q    = (in_use_q >= slot_q[idx].size) ? in_use_q - slot_q[idx].size : '0;
            live_q[idx] = 1'b0;
          end
          OpEvict: begin
            if (slot_q[idx].pinned) rsp.status = StPinned;
            else slot_q[idx].residency = ResCold;
            rsp.entry_state = slot_q[idx].residency;
          end
          OpPromote: begin
            slot_q[idx].residency = ResHot;
            rsp.entry_state       = ResHot;
          end
          OpPin: begin
            slot_q[idx].pinned    = 1'b1;
            slot_q[idx].residency = ResPinned;
            rsp.entry_state       = ResPinned;
          end
          OpUnpin: begin
            slot_q[idx].pinned    = 1'b0;
            slot_q[idx].residency = ResHot;
            rsp.entry_state       = ResHot;
          end
          default: ;
        endcase
      end
    end
    rsp.free_bytes = (capacity_q > in_use_q) ? capacity_q - in_use_q : '0;
    return rsp;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int   i;
    rsp_t want;
    if (!rst_ni) begin
      capacity_q = CapReset;
      in_use_q   = '0;
      bump_q     = '0;
      for (i = 0; i < TableEntries; i++) live_q[i] = 1'b0;
      owed_q.delete();
      owed_o <= 0;
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) owed_q.push_back(apply_request(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $display("%0t: response transaction with none owed, expected none, actual 0x%0h",
                   $time, out_rsp_i);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          compare_field("status", 64'(want.status), 64'(out_rsp_i.status));
          compare_field("granted_address", 64'(want.granted_address),
                        64'(out_rsp_i.granted_address));
          compare_field("entry_state", 64'(want.entry_state), 64'(out_rsp_i.entry_state));
          compare_field("free_bytes", 64'(want.free_bytes), 64'(out_rsp_i.free_bytes));
        end
      end
      owed_o <= owed_q.size();
    end
  end

endmodule

// File: tb/bump_allocator_residency_table_core_tb.sv
// ----------------------------------------------------------------------------
// bump_allocator_residency_table_core_tb
// Drives allocate, free, evict, promote, pin, unpin and undefined requests
// into the allocator under several capacity settings, with random gaps and
// receiver stalls, and lets the allocation checker judge every response.
// ----------------------------------------------------------------------------
module bump_allocator_residency_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bart_pkg::*;

  localparam int KeyPool      = 80;
  localparam int SettleCycles = 80;
  localparam int PhaseItems   = 230;
  localparam int WrapPairs    = 132;

  localparam logic [OpW-1:0]   OpSpare6 = 3'd6;
  localparam logic [OpW-1:0]   OpSpare7 = 3'd7;
  localparam logic [SizeW-1:0] CapMax   = '1;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  req_t             in_req_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rsp_t             out_rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  int               owed;
  int               fail_count;
  logic             calm        = 1'b0;
  logic [KeyW-1:0]  key_pool [KeyPool];
  int               sent_by_op [8];
  int               cap_writes  = 0;

  bump_allocator_residency_table_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_rsp_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  bart_allocation_checker u_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .in_req_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .out_rsp_i    (out_rsp_o),
    .cfg_we_i,
    .cfg_wdata_i,
    .owed_o       (owed),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #25_000_000;
    $display("Timed out with %0d responses still owed.", owed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, now and then a long one so that a finished
  // response has to wait while the next request is being worked on.
  initial begin : receiver
    int hold;
    forever begin
      @(posedge clk_i);
      if (calm || !rst_ni) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        hold = $urandom_range(40, 150);
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 31);
      end
    end
  end

  function automatic req_t request(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                                   input logic [SizeW-1:0] size);
    req_t req;
    req.operation    = op;
    req.tensor_key   = key;
    req.request_size = size;
    return req;
  endfunction

  // Mostly small sizes; a few span the whole field.
  function automatic logic [SizeW-1:0] random_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SizeW'($urandom_range(0, 4095));
    if (roll < 75) return SizeW'(64 * $urandom_range(0, 32));
    if (roll < 92) return SizeW'($urandom_range(0, 1 << 20));
    return SizeW'({$urandom, $urandom});
  endfunction

  function automatic logic [OpW-1:0] random_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 36) return OpAlloc;
    if (roll < 50) return OpFree;
    if (roll < 62) return OpEvict;
    if (roll < 72) return OpPromote;
    if (roll < 84) return OpPin;
    if (roll < 95) return OpUnpin;
    return roll[0] ? OpSpare6 : OpSpare7;
  endfunction

  // Keys mostly come from a pool a little larger than the table, so that
  // lookups hit and the table fills up; a few are fresh.
  function automatic req_t random_req();
    logic [KeyW-1:0] key;
    if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(0, KeyPool - 1)];
    return request(random_op(), key, random_size());
  endfunction

  task automatic issue(input req_t req);
    if (!calm && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 120)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_by_op[req.operation]++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [SizeW-1:0] capacity);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= capacity;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_writes++;
  endtask

  initial begin : stimulus
    int               i;
    int               ph;
    logic [SizeW-1:0] phase_cap [4];
    logic [KeyW-1:0]  wrap_key;
    logic [SizeW-1:0] wrap_size;

    phase_cap = '{41'h100_0000_0000, CapMax, 41'd300_000, CapReset};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < KeyPool; i++) key_pool[i] = {$urandom, $urandom};
    for (i = 0; i < 8; i++) sent_by_op[i] = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset capacity.
    issue(request(OpPromote, '0, '0));
    issue(request(OpAlloc, '0, '0));
    issue(request(OpAlloc, key_pool[3], 41'd1));
    issue(request(OpAlloc, key_pool[3], 41'd100));
    issue(request(OpEvict, key_pool[3], '0));
    issue(request(OpPin, key_pool[3], '0));
    issue(request(OpEvict, key_pool[3], '0));
    issue(request(OpPromote, key_pool[3], '0));
    issue(request(OpEvict, key_pool[3], '0));
    issue(request(OpUnpin, key_pool[3], '0));
    issue(request(OpEvict, key_pool[3], '0));
    issue(request(OpFree, key_pool[3], '0));
    issue(request(OpFree, key_pool[3], '0));
    issue(request(OpSpare6, key_pool[2], random_size()));
    issue(request(OpSpare7, '1, '1));
    // One byte is still counted after the overwrite and free above, so this
    // fills the domain exactly.
    issue(request(OpAlloc, '1, CapReset - 41'd1));
    issue(request(OpAlloc, key_pool[2], 41'd1));
    issue(request(OpAlloc, key_pool[2], '1));
    issue(request(OpFree, '1, '0));
    issue(request(OpPin, '0, '0));
    issue(request(OpUnpin, '0, '0));

    // Capacity below the bytes in use.
    reconfigure('0);
    issue(request(OpAlloc, key_pool[2], '0));
    issue(request(OpFree, '0, '0));
    issue(request(OpAlloc, key_pool[2], 41'd5));

    // Near full-scale allocate and free pairs walk the pointer past 2^48.
    reconfigure(CapMax);
    for (i = 0; i < WrapPairs; i++) begin
      wrap_key  = {$urandom, $urandom};
      wrap_size = {9'h1FF, $urandom};
      issue(request(OpAlloc, wrap_key, wrap_size));
      issue(request(OpFree, wrap_key, random_size()));
    end

    for (ph = 0; ph < 4; ph++) begin
      reconfigure(phase_cap[ph]);
      calm = (ph == 0);
      for (i = 0; i < PhaseItems; i++) begin
        issue(random_req());
        if ($urandom_range(0, 79) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d allocate, %0d free, %0d evict, %0d promote, %0d pin, %0d unpin",
             sent_by_op[OpAlloc], sent_by_op[OpFree], sent_by_op[OpEvict],
             sent_by_op[OpPromote], sent_by_op[OpPin], sent_by_op[OpUnpin]);
    $display("and %0d undefined requests over %0d capacity writes, zero and full scale included.",
             sent_by_op[OpSpare6] + sent_by_op[OpSpare7], cap_writes);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bart_pkg.sv
src/bart_alu.sv
src/bart_table.sv
src/bump_allocator_residency_table_core.sv
tb/bart_allocation_checker.sv
tb/bump_allocator_residency_table_core_tb.sv
